// ----- sv/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, sync codes and the byte-wise CRC-16 update for the sync frame
// deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [3:0]  index_type;

   localparam byte_type SYNC_A         = 8'h3E;
   localparam byte_type SYNC_B         = 8'h2A;
   localparam word_type CRC_SEED_RESET = 16'h00FF;

   function automatic word_type crc_step(input word_type crc, input byte_type b);
      byte_type d;
      word_type d16;
      d   = b ^ crc[7:0];
      d   = d ^ {d[3:0], 4'b0000};
      d16 = {8'h00, d};
      return {d, crc[15:8]} ^ (d16 >> 4) ^ (d16 << 3);
   endfunction

endpackage

// ----- sv/sfd_ram.sv -----
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 14
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/sync_frame_deframer_crc16.sv -----
// ----------------------------------------------------------------------------
// sync_frame_deframer_crc16
// Hunts for the '>' '*' '>' sync, keeps the tag in a register and the payload
// words in a RAM, checks the CRC-16 and replays the payload words of a good frame.
// ----------------------------------------------------------------------------
// Input: one byte per cycle, except while a good frame drains.
// Drain: each payload word passes through the RAM read data register and then
//   the output register; the next read waits until the previous one has landed
//   and the output register is free or taken, with input held off until the last read.
// Reset: synchronous, clears control state and loads seed_ff and crc_ff with 0x00FF;
//   the payload RAM is not cleared.
module sync_frame_deframer_crc16 #(
   parameter int PAYLOAD_WORDS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sfd_pkg::byte_type     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfd_pkg::word_type     rsp_word_value,
   output sfd_pkg::index_type    rsp_word_index,
   output sfd_pkg::byte_type     rsp_frame_tag,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  sfd_pkg::word_type     csr_data
);

   import sfd_pkg::*;

   localparam int AW    = PAYLOAD_WORDS > 1 ? $clog2(PAYLOAD_WORDS) : 1;
   localparam int CNT_W = $clog2(2 * PAYLOAD_WORDS);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_SYNC1 = 3'd1;
   localparam logic [2:0] PH_SYNC2 = 3'd2;
   localparam logic [2:0] PH_TAG   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_CRCLO = 3'd5;
   localparam logic [2:0] PH_CRCHI = 3'd6;
   localparam logic [2:0] PH_DRAIN = 3'd7;

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   word_type         seed_ff, seed_in;
   word_type         crc_ff, crc_in;
   byte_type         tag_ff, tag_in;
   byte_type         low_ff, low_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             out_valid_ff, out_valid_in;
   word_type         out_value_ff, out_value_in;
   index_type        out_index_ff, out_index_in;
   byte_type         out_tag_ff, out_tag_in;
   logic             out_last_ff, out_last_in;

   logic             in_xfer;
   logic             issue;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   word_type         rd_data;

   assign req_ready = (phase_ff != PH_DRAIN);
   assign csr_ready = 1'b1;
   assign in_xfer   = req_valid && req_ready;
   assign issue     = (phase_ff == PH_DRAIN) && !rd_pend_ff && (!out_valid_ff || rsp_ready);
   assign wr_en     = in_xfer && (phase_ff == PH_DATA) && count_ff[0];
   assign wr_addr   = AW'(count_ff >> 1);

   sfd_ram #(
      .WIDTH (16),
      .DEPTH (PAYLOAD_WORDS)
   ) u_payload (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_rx_byte, low_ff}),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      seed_in      = seed_ff;
      crc_in       = crc_ff;
      tag_in       = tag_ff;
      low_in       = low_ff;
      rd_idx_in    = rd_idx_ff;
      pend_idx_in  = pend_idx_ff;
      rd_pend_in   = issue;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;

      if (csr_valid && csr_ready) begin
         seed_in = csr_data;
      end

      if (in_xfer) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (req_rx_byte == SYNC_B) begin
                  phase_in = PH_SYNC2;
               end else if (req_rx_byte == SYNC_A) begin
                  phase_in = PH_SYNC1;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SYNC2: phase_in = (req_rx_byte == SYNC_A) ? PH_TAG : PH_HUNT;
            PH_TAG: begin
               tag_in   = req_rx_byte;
               crc_in   = seed_ff;
               count_in = '0;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               crc_in = crc_step(crc_ff, req_rx_byte);
               if (!count_ff[0]) begin
                  low_in = req_rx_byte;
               end
               if (count_ff == CNT_W'(2 * PAYLOAD_WORDS - 1)) begin
                  count_in = '0;
                  phase_in = PH_CRCLO;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_CRCLO: begin
               low_in   = req_rx_byte;
               phase_in = PH_CRCHI;
            end
            PH_CRCHI: begin
               rd_idx_in = '0;
               phase_in  = ({req_rx_byte, low_ff} == crc_ff) ? PH_DRAIN : PH_HUNT;
            end
            default: phase_in = (req_rx_byte == SYNC_A) ? PH_SYNC1 : PH_HUNT;
         endcase
      end

      // advance the drain read pointer; hand back to the hunt after the last read
      if (issue) begin
         pend_idx_in = rd_idx_ff;
         if (rd_idx_ff == AW'(PAYLOAD_WORDS - 1)) begin
            rd_idx_in = '0;
            phase_in  = PH_HUNT;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end

      if (rd_pend_ff) begin
         out_valid_in = 1'b1;
         out_value_in = rd_data;
         out_index_in = 4'(pend_idx_ff);
         out_tag_in   = tag_ff;
         out_last_in  = (pend_idx_ff == AW'(PAYLOAD_WORDS - 1));
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         seed_ff      <= CRC_SEED_RESET;
         crc_ff       <= CRC_SEED_RESET;
         tag_ff       <= '0;
         low_ff       <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         seed_ff      <= seed_in;
         crc_ff       <= crc_in;
         tag_ff       <= tag_in;
         low_ff       <= low_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_tag_ff   <= out_tag_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_word_value = out_value_ff;
   assign rsp_word_index = out_index_ff;
   assign rsp_frame_tag  = out_tag_ff;
   assign rsp_last       = out_last_ff;

   a_pend_fills: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> out_valid_ff)
      else $error("read data lost");

   a_pend_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !out_valid_ff)
      else $error("read returned into a full output register");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_index_ff == 4'(PAYLOAD_WORDS - 1)))
      else $error("last mark on wrong word");

   a_crclo_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CRCLO) |-> ($past(phase_ff) == PH_DATA || $past(phase_ff) == PH_CRCLO))
      else $error("CRC phase entered out of order");

endmodule

// ----- tb/sync_frame_deframer_crc16_test.sv -----
// ----------------------------------------------------------------------------
// sync_frame_deframer_crc16_test
// Feeds received bytes (sync fragments, good frames, frames with a damaged
// CRC or payload, noise) through the deframer, mostly under random idling on both
// channels, predicts every payload word of each good frame with a bit-wise
// CRC-16 and compares the words field by field as they are transferred.
// The seed register is rewritten between phases, once in mid-frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_frame_deframer_crc16_test;

   import sfd_pkg::*;

   localparam int PAYLOAD_WORDS = 14;
   localparam int DRAIN_CYCLES  = 2 * PAYLOAD_WORDS + 8;
   localparam int HOLD_CYCLES   = 300;

   typedef enum logic [2:0] {
      LOOK_A, GOT_A, GOT_AB, TAKE_TAG, TAKE_DATA, TAKE_CRC_LO, TAKE_CRC_HI
   } deframe_state_type;

   typedef struct packed {
      word_type  value;
      index_type index;
      byte_type  tag;
      logic      last;
   } word_result_type;

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      req_valid   = 1'b0;
   logic      req_ready;
   byte_type  req_rx_byte = '0;
   logic      rsp_valid;
   logic      rsp_ready   = 1'b0;
   word_type  rsp_word_value;
   index_type rsp_word_index;
   byte_type  rsp_frame_tag;
   logic      rsp_last;
   logic      csr_valid   = 1'b0;
   logic      csr_ready;
   word_type  csr_data    = '0;

   // predicted deframer state
   deframe_state_type m_state = LOOK_A;
   logic [5:0]        m_count = '0;
   word_type          m_crc   = CRC_SEED_RESET;
   word_type          m_seed  = CRC_SEED_RESET;
   byte_type          m_tag   = '0;
   byte_type          m_low   = '0;
   word_type          m_words [PAYLOAD_WORDS];

   byte_type        pend_bytes [$];
   byte_type        frame_buf [$];
   word_result_type word_q [$];
   word_result_type want_word;

   int req_gap = 0;
   int rsp_wait = 0;
   int hold_off_left = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int n_errors = 0;
   int n_bytes = 0;
   int n_words = 0;
   int n_good = 0;
   int n_dropped = 0;
   int n_seeds = 0;

   sync_frame_deframer_crc16 #(
      .PAYLOAD_WORDS(PAYLOAD_WORDS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_value (rsp_word_value),
      .rsp_word_index (rsp_word_index),
      .rsp_frame_tag  (rsp_frame_tag),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // reflected CCITT, one bit at a time
   function automatic word_type crc_next(input word_type c, input byte_type b);
      word_type r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      n_errors++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic predict_byte(input byte_type b);
      word_result_type w;
      case (m_state)
         GOT_A: begin
            if (b == SYNC_B) m_state = GOT_AB;
            else m_state = (b == SYNC_A) ? GOT_A : LOOK_A;
         end
         GOT_AB: m_state = (b == SYNC_A) ? TAKE_TAG : LOOK_A;
         TAKE_TAG: begin
            m_tag   = b;
            m_crc   = m_seed;
            m_count = '0;
            m_state = TAKE_DATA;
         end
         TAKE_DATA: begin
            m_crc = crc_next(m_crc, b);
            if (!m_count[0]) m_low = b;
            else m_words[m_count[4:1]] = {b, m_low};
            m_count = m_count + 6'd1;
            if (m_count >= 2 * PAYLOAD_WORDS) m_state = TAKE_CRC_LO;
         end
         TAKE_CRC_LO: begin
            m_low   = b;
            m_state = TAKE_CRC_HI;
         end
         TAKE_CRC_HI: begin
            if ({b, m_low} == m_crc) begin
               n_good++;
               for (int k = 0; k < PAYLOAD_WORDS; k++) begin
                  w.value = m_words[k];
                  w.index = index_type'(k);
                  w.tag   = m_tag;
                  w.last  = (k == PAYLOAD_WORDS - 1);
                  word_q.push_back(w);
               end
            end else begin
               n_dropped++;
            end
            m_state = LOOK_A;
         end
         default: m_state = (b == SYNC_A) ? GOT_A : LOOK_A;
      endcase
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {SYNC_B, SYNC_A};
         default: return word_type'($urandom);
      endcase
   endfunction

   // frame_buf <- sync, tag, payload, CRC under the current seed
   task automatic build_frame(input byte_type tag, input bit corrupt, input bit fixed);
      word_type c;
      word_type w;
      int spot;
      frame_buf.delete();
      frame_buf.push_back(SYNC_A);
      frame_buf.push_back(SYNC_B);
      frame_buf.push_back(SYNC_A);
      frame_buf.push_back(tag);
      c = m_seed;
      for (int k = 0; k < PAYLOAD_WORDS; k++) begin
         if (fixed) w = (k == 7) ? {SYNC_B, SYNC_A} : ((k % 2) ? 16'hFFFF : 16'h0000);
         else w = pick_word();
         frame_buf.push_back(w[7:0]);
         frame_buf.push_back(w[15:8]);
         c = crc_next(crc_next(c, w[7:0]), w[15:8]);
      end
      if (corrupt) begin
         if ($urandom_range(0, 1)) begin
            c = c ^ word_type'($urandom_range(1, 16'hFFFF));
         end else begin
            spot = $urandom_range(4, 4 + 2 * PAYLOAD_WORDS - 1);
            frame_buf[spot] = frame_buf[spot] ^ byte_type'($urandom_range(1, 255));
         end
      end
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic build_noise();
      int n;
      frame_buf.delete();
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         case ($urandom_range(0, 3))
            0: frame_buf.push_back(SYNC_A);
            1: frame_buf.push_back(SYNC_B);
            default: frame_buf.push_back(byte_type'($urandom));
         endcase
   endtask

   task automatic add_traffic(input int budget);
      int added;
      int r;
      added = 0;
      while (added < budget) begin
         r = $urandom_range(0, 99);
         if (r < 80) build_frame(byte_type'($urandom), r >= 60, 1'b0);
         else build_noise();
         foreach (frame_buf[i]) pend_bytes.push_back(frame_buf[i]);
         added += frame_buf.size();
      end
   endtask

   task automatic wait_quiet();
      while (pend_bytes.size() != 0 || req_valid || word_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input word_type v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      m_seed = v;
      n_seeds++;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte(req_rx_byte);
            n_bytes++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pend_bytes.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pend_bytes.pop_front();
               req_gap = req_calm ? 0 : $urandom_range(0, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_words++;
            if (word_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h index %0d tag %h last %b",
                  rsp_word_value, rsp_word_index, rsp_frame_tag, rsp_last));
            end else begin
               want_word = word_q.pop_front();
               if (rsp_word_value !== want_word.value)
                  report_mismatch($sformatf("word_value %h, want %h at index %0d",
                     rsp_word_value, want_word.value, want_word.index));
               if (rsp_word_index !== want_word.index)
                  report_mismatch($sformatf("word_index %0d, want %0d",
                     rsp_word_index, want_word.index));
               if (rsp_frame_tag !== want_word.tag)
                  report_mismatch($sformatf("frame_tag %h, want %h at index %0d",
                     rsp_frame_tag, want_word.tag, want_word.index));
               if (rsp_last !== want_word.last)
                  report_mismatch($sformatf("last %b, want %b at index %0d",
                     rsp_last, want_word.last, want_word.index));
            end
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 11);
         end
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed: extreme bytes, broken syncs, repeated first sync byte, fixed frame
      pend_bytes.push_back(8'h00);
      pend_bytes.push_back(8'hFF);
      pend_bytes.push_back(SYNC_A);
      pend_bytes.push_back(8'h00);
      pend_bytes.push_back(SYNC_A);
      pend_bytes.push_back(SYNC_B);
      pend_bytes.push_back(8'h55);
      pend_bytes.push_back(SYNC_A);
      build_frame(8'h00, 1'b0, 1'b1);
      foreach (frame_buf[i]) pend_bytes.push_back(frame_buf[i]);
      wait_quiet();

      // no idling on either side
      write_seed(16'h0000);
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      add_traffic(10);
      wait_quiet();

      // hold the receiver off while a good frame and more bytes keep coming
      write_seed(16'hFFFF);
      rsp_calm = 1'b0;
      hold_off_left <= HOLD_CYCLES;
      build_frame(byte_type'($urandom), 1'b0, 1'b0);
      foreach (frame_buf[i]) pend_bytes.push_back(frame_buf[i]);
      build_noise();
      foreach (frame_buf[i]) pend_bytes.push_back(frame_buf[i]);
      wait_quiet();

      write_seed(word_type'($urandom));
      req_calm = 1'b0;
      // stop in mid-payload so the next seed arrives while the CRC runs
      build_frame(byte_type'($urandom), 1'b0, 1'b0);
      for (int i = 0; i < 12; i++) pend_bytes.push_back(frame_buf[i]);
      wait_quiet();

      write_seed(word_type'($urandom));
      for (int i = 12; i < frame_buf.size(); i++) pend_bytes.push_back(frame_buf[i]);
      add_traffic(10);
      wait_quiet();

      $display("covered %0d bytes: %0d good frames, %0d dropped on CRC, %0d seed writes",
         n_bytes, n_good, n_dropped, n_seeds);
      $display("checked %0d payload words, %0d mismatches", n_words, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/sfd_pkg.sv
sv/sfd_ram.sv
sv/sync_frame_deframer_crc16.sv
tb/sync_frame_deframer_crc16_test.sv
